### src/ffa_pkg.sv
package ffa_pkg;

  // Default geometry of the arena
  localparam int ARENA_BYTES_DEF   = 1024;
  localparam int GRANULE_BYTES_DEF = 16;
  localparam int HEADER_BYTES_DEF  = 16;

  // Smallest data area worth splitting off as a new free block
  localparam int MIN_SPLIT_BYTES = 16;

  // Field widths
  localparam int REQ_W    = 12;
  localparam int OFFS_W   = 10;
  localparam int STATUS_W = 2;

  // Item kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // Input word
  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFFS_W-1:0] release_offset;
  } ffa_in_t;

  // Result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFS_W-1:0]   data_offset;
  } ffa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic divide;
    logic prep;
    logic alloc_step;
    logic free_step;
    logic res_load;
  } ffa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;
    logic bad_free;
    logic found;
    logic at_last;
    logic at_end;
  } ffa_sts_t;

endpackage

### src/ffa_dp.sv
module ffa_dp import ffa_pkg::*; #(
  parameter int ARENA_BYTES   = ARENA_BYTES_DEF,
  parameter int GRANULE_BYTES = GRANULE_BYTES_DEF,
  parameter int HEADER_BYTES  = HEADER_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ffa_in_t  in_data_i,
  input  ffa_cmd_t cmd_i,
  output ffa_sts_t sts_o,
  output ffa_out_t out_data_o
);

  // Geometry in granules
  localparam int NGRAN   = ARENA_BYTES / GRANULE_BYTES;
  localparam int HG      = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int HDR_PAD = HG * GRANULE_BYTES;
  localparam int SPLIT_G = (MIN_SPLIT_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int IW      = $clog2(NGRAN);
  localparam int GW      = $clog2(NGRAN + 1);
  localparam int GBW     = $clog2(GRANULE_BYTES + 1);

  // Division by the granule size: multiply by a rounded-up reciprocal
  localparam int DXW   = REQ_W + 1;
  localparam int SH    = DXW + $clog2(GRANULE_BYTES);
  localparam int RECIP = (2 ** SH + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = DXW + RW;
  localparam int QW    = (DXW > GW) ? DXW : GW;
  localparam int CW    = QW + 2;
  localparam int BW    = QW + GBW;
  localparam int OW    = GW + GBW + 1;

  ffa_in_t             in_q;
  logic [QW-1:0]       quo_q;
  logic [GW-1:0]       g_q;
  logic [GW-1:0]       cs_q;
  logic                cfree_q;
  logic                hb_q;
  logic                pf_q;
  logic [NGRAN-1:0]    start_q;
  logic [NGRAN-1:0]    used_q;
  logic [STATUS_W-1:0] st_q;
  logic [OFFS_W-1:0]   offs_q;
  ffa_out_t            res_q;

  logic [OFFS_W-1:0] rel;
  logic [DXW-1:0]    div_x;
  logic [PW-1:0]     prod;
  logic [QW-1:0]     quo_d;
  logic [IW-1:0]     q_idx;
  logic              q_in;
  logic [BW-1:0]     back;
  logic              bad;
  logic              is_free;
  logic [IW-1:0]     g_idx;
  logic [IW-1:0]     cs_idx;
  logic [IW-1:0]     m_idx;
  logic              at_end;
  logic              at_last;
  logic              bnd;
  logic [CW-1:0]     len;
  logic [CW-1:0]     m;
  logic              fit;
  logic              split;
  logic [OW-1:0]     offs_full;

  // Quotient: padded granules for an allocate, block index for a free
  assign is_free = (in_q.kind == KIND_FREE);
  assign rel     = in_q.release_offset - OFFS_W'(HDR_PAD);
  assign div_x   = is_free ? DXW'(rel)
                           : (DXW'(in_q.request_bytes) + DXW'(GRANULE_BYTES - 1));
  assign prod    = PW'(div_x) * PW'(RECIP);
  assign quo_d   = QW'(prod >> SH);

  // Free offset check
  assign q_idx = quo_q[IW-1:0];
  assign q_in  = (quo_q < QW'(NGRAN));
  assign back  = BW'(quo_q) * BW'(GRANULE_BYTES);
  assign bad   = (in_q.release_offset < OFFS_W'(HDR_PAD)) || (BW'(rel) != back) ||
                 !q_in || !start_q[q_idx] || !used_q[q_idx];

  // Scan position
  assign g_idx   = g_q[IW-1:0];
  assign cs_idx  = cs_q[IW-1:0];
  assign at_end  = (g_q == GW'(NGRAN));
  assign at_last = (g_q == GW'(NGRAN - 1));
  assign bnd     = at_end || start_q[g_idx];

  // Fit and split test for the block that ends at the scan position
  assign len   = CW'(g_q - cs_q);
  assign fit   = hb_q && cfree_q && bnd && (len >= CW'(quo_q) + CW'(HG));
  assign split = (len >= CW'(quo_q) + CW'(2 * HG + SPLIT_G));
  assign m     = CW'(cs_q) + CW'(HG) + CW'(quo_q);
  assign m_idx = m[IW-1:0];

  assign offs_full = OW'(cs_q) * OW'(GRANULE_BYTES) + OW'(HDR_PAD);

  // Block maps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= NGRAN'(1);
      used_q  <= '0;
    end else begin
      if (cmd_i.prep && is_free && !bad) begin
        used_q[q_idx] <= 1'b0;
      end
      if (cmd_i.alloc_step && fit) begin
        used_q[cs_idx] <= 1'b1;
        if (split) begin
          start_q[m_idx] <= 1'b1;
          used_q[m_idx]  <= 1'b0;
        end
      end
      // merge: drop a free block start that follows a free block
      if (cmd_i.free_step && start_q[g_idx] && !used_q[g_idx] && pf_q) begin
        start_q[g_idx] <= 1'b0;
      end
    end
  end

  // Working registers and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.divide) begin
      quo_q <= quo_d;
    end
    if (cmd_i.prep) begin
      g_q     <= '0;
      cs_q    <= '0;
      hb_q    <= 1'b0;
      cfree_q <= 1'b0;
      pf_q    <= 1'b0;
      offs_q  <= '0;
      if (is_free) begin
        st_q <= bad ? ST_BAD_FREE : ST_DONE;
      end else begin
        st_q <= ST_NO_FIT;
      end
    end
    if (cmd_i.alloc_step) begin
      if (fit) begin
        st_q   <= ST_DONE;
        offs_q <= offs_full[OFFS_W-1:0];
      end else begin
        if (bnd) begin
          cs_q    <= g_q;
          cfree_q <= !used_q[g_idx];
          hb_q    <= 1'b1;
        end
        g_q <= g_q + GW'(1);
      end
    end
    if (cmd_i.free_step) begin
      if (start_q[g_idx]) begin
        pf_q <= !used_q[g_idx];
      end
      g_q <= g_q + GW'(1);
    end
    if (cmd_i.res_load) begin
      res_q.status      <= st_q;
      res_q.data_offset <= offs_q;
    end
  end

  assign sts_o.is_free  = is_free;
  assign sts_o.bad_free = bad;
  assign sts_o.found    = fit;
  assign sts_o.at_last  = at_last;
  assign sts_o.at_end   = at_end;

  assign out_data_o = res_q;

endmodule

### src/ffa_ctrl.sv
module ffa_ctrl import ffa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ffa_sts_t sts_i,
  output ffa_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_ALLOC,
    S_FREE,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   res_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  // result register free or being emptied this cycle
  assign res_ok      = !out_valid_q || out_ready_i;

  // Command decode
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.capture    = in_valid_i;
      S_DIV:    cmd_o.divide     = 1'b1;
      S_PREP:   cmd_o.prep       = 1'b1;
      S_ALLOC:  cmd_o.alloc_step = 1'b1;
      S_FREE:   cmd_o.free_step  = 1'b1;
      S_FINISH: cmd_o.res_load   = res_ok;
      default:  cmd_o = '0;
    endcase
  end

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DIV;
        end
        S_DIV: begin
          state_q <= S_PREP;
        end
        S_PREP: begin
          if (!sts_i.is_free) begin
            state_q <= S_ALLOC;
          end else if (sts_i.bad_free) begin
            state_q <= S_FINISH;
          end else begin
            state_q <= S_FREE;
          end
        end
        S_ALLOC: begin
          if (sts_i.found || sts_i.at_end) state_q <= S_FINISH;
        end
        S_FREE: begin
          if (sts_i.at_last) state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ok) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### src/first_fit_arena_allocator.sv
// An allocate scans granules up to the chosen block, a free scans all N granules of the arena,
//   a rejected free scans none; N = ARENA_BYTES / GRANULE_BYTES (64 by default).
// Throughput: one word at a time; the granule scan, one granule per cycle, sets the rate.
// A finished result waits in an output register while the next word is taken.
// Reset (async, active low): the arena is one free block starting at granule zero.
module first_fit_arena_allocator import ffa_pkg::*; #(
  parameter int ARENA_BYTES   = ARENA_BYTES_DEF,
  parameter int GRANULE_BYTES = GRANULE_BYTES_DEF,
  parameter int HEADER_BYTES  = HEADER_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ffa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ffa_out_t out_data_o
);

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  // Sequencer
  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Block maps and arithmetic
  ffa_dp #(
    .ARENA_BYTES   (ARENA_BYTES),
    .GRANULE_BYTES (GRANULE_BYTES),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

### tb/sv/first_fit_arena_allocator_test.sv
`timescale 1ns / 1ps

module first_fit_arena_allocator_test;
  import ffa_pkg::*;

  // Arena geometry as the block is built here
  localparam int GRAN      = GRANULE_BYTES_DEF;
  localparam int NUM_GRAN  = ARENA_BYTES_DEF / GRAN;
  localparam int HDR_GRAN  = (HEADER_BYTES_DEF + GRAN - 1) / GRAN;
  localparam int HDR_PAD   = HDR_GRAN * GRAN;

  localparam int NUM_RANDOM   = 1823;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 100;

  // Directed stimulus row; st/offs are used only where typed is set
  typedef struct packed {
    logic                kind;
    logic [REQ_W-1:0]    req;
    logic [OFFS_W-1:0]   rel;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [OFFS_W-1:0]   offs;
  } dir_row_t;

  localparam int NUM_DIR = 27;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  ffa_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ffa_out_t out_data_o;

  first_fit_arena_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of the block maps
  logic [NUM_GRAN-1:0] shadow_starts;
  logic [NUM_GRAN-1:0] shadow_used;

  ffa_out_t pending_results[$];
  int       live_offsets[$];
  int       errors = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;

  // Receiver stall pattern state
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall_left = 0;
  logic rx_ready_next;

  dir_row_t dir_rows [NUM_DIR];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Granule index of the next block start after g, or NUM_GRAN
  function automatic int next_block(input int g);
    int k;
    for (k = g + 1; k < NUM_GRAN; k++) begin
      if (shadow_starts[k]) return k;
    end
    return NUM_GRAN;
  endfunction

  // First-fit allocate with split of a large enough remainder
  function automatic ffa_out_t predict_alloc(input int req);
    int padded;
    int g;
    int data_sz;
    int m;
    ffa_out_t r;
    padded = (req + GRAN - 1) / GRAN * GRAN;
    r.status = ST_NO_FIT;
    r.data_offset = '0;
    for (g = 0; g < NUM_GRAN; g++) begin
      if (shadow_starts[g] && !shadow_used[g]) begin
        data_sz = (next_block(g) - g) * GRAN - HDR_PAD;
        if (data_sz >= padded) begin
          if (data_sz >= padded + HDR_PAD + MIN_SPLIT_BYTES) begin
            m = g + HDR_GRAN + padded / GRAN;
            if (m < NUM_GRAN) begin
              shadow_starts[m] = 1'b1;
              shadow_used[m] = 1'b0;
            end
          end
          shadow_used[g] = 1'b1;
          r.status = ST_DONE;
          r.data_offset = OFFS_W'(g * GRAN + HDR_PAD);
          return r;
        end
      end
    end
    return r;
  endfunction

  // Release a block, then merge every run of adjacent free blocks
  function automatic ffa_out_t predict_release(input int off);
    int rel;
    int g;
    bit prev_free;
    ffa_out_t r;
    r.status = ST_BAD_FREE;
    r.data_offset = '0;
    prev_free = 1'b0;
    if (off < HDR_PAD) return r;
    rel = off - HDR_PAD;
    if ((rel % GRAN) != 0) return r;
    g = rel / GRAN;
    if (g >= NUM_GRAN) return r;
    if (!shadow_starts[g] || !shadow_used[g]) return r;
    shadow_used[g] = 1'b0;
    for (g = 0; g < NUM_GRAN; g++) begin
      if (shadow_starts[g]) begin
        if (shadow_used[g]) begin
          prev_free = 1'b0;
        end else if (prev_free) begin
          shadow_starts[g] = 1'b0;
        end else begin
          prev_free = 1'b1;
        end
      end
    end
    r.status = ST_DONE;
    return r;
  endfunction

  // Drive one word in a burst/gap pattern, then predict it once accepted
  task automatic send_word(input ffa_in_t w, input logic typed, input ffa_out_t want);
    int gap;
    int i;
    ffa_out_t got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (w.kind == KIND_ALLOC) begin
      got = predict_alloc(int'(w.request_bytes));
    end else begin
      got = predict_release(int'(w.release_offset));
    end
    pending_results.push_back(typed ? want : got);
    // track live blocks for well-formed frees
    if (got.status == ST_DONE) begin
      if (w.kind == KIND_ALLOC) begin
        live_offsets.push_back(int'(got.data_offset));
      end else begin
        for (i = 0; i < live_offsets.size(); i++) begin
          if (live_offsets[i] == int'(w.release_offset)) begin
            live_offsets.delete(i);
            break;
          end
        end
      end
    end
  endtask

  // Result check and receiver stall pattern
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: status %0d, data_offset %0d",
               out_data_o.status, out_data_o.data_offset);
        errors++;
      end else begin
        if (out_data_o.status !== pending_results[0].status) begin
          $error("status: expected %0d, got %0d", pending_results[0].status,
                 out_data_o.status);
          errors++;
        end
        if (out_data_o.data_offset !== pending_results[0].data_offset) begin
          $error("data_offset: expected %0d, got %0d", pending_results[0].data_offset,
                 out_data_o.data_offset);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 400);
    end
    rx_mode_left--;
    case (rx_mode)
      0: begin
        rx_ready_next = 1'b1;
      end
      1: begin
        rx_ready_next = ($urandom_range(0, 3) != 0);
      end
      2: begin
        rx_ready_next = ((rx_mode_left % 3) == 0);
      end
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          rx_ready_next = 1'b0;
        end else begin
          rx_ready_next = 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 80);
        end
      end
    endcase
    out_ready_i <= rx_ready_next;
  end

  // Cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, random words, drain
  initial begin
    ffa_in_t  w;
    ffa_out_t want;
    int       n;
    int       pick;
    int       sz_sel;

    dir_rows = '{
      // after reset: only one free block
      '{KIND_FREE,  12'd0,    10'd16,   1'b1, ST_BAD_FREE, 10'd0},
      '{KIND_FREE,  12'd0,    10'd0,    1'b1, ST_BAD_FREE, 10'd0},
      '{KIND_FREE,  12'hFFF,  10'd1023, 1'b1, ST_BAD_FREE, 10'd0},
      // too large, then exact fit of the whole arena
      '{KIND_ALLOC, 12'd4095, 10'd0,    1'b1, ST_NO_FIT,   10'd0},
      '{KIND_ALLOC, 12'd1009, 10'd1023, 1'b1, ST_NO_FIT,   10'd0},
      '{KIND_ALLOC, 12'd1008, 10'd0,    1'b1, ST_DONE,     10'd16},
      '{KIND_ALLOC, 12'd0,    10'd0,    1'b1, ST_NO_FIT,   10'd0},
      '{KIND_FREE,  12'd0,    10'd16,   1'b1, ST_DONE,     10'd0},
      // zero-byte request splits, then padded small requests
      '{KIND_ALLOC, 12'd0,    10'd0,    1'b1, ST_DONE,     10'd16},
      '{KIND_ALLOC, 12'd1,    10'd0,    1'b1, ST_DONE,     10'd32},
      '{KIND_ALLOC, 12'd15,   10'd0,    1'b1, ST_DONE,     10'd64},
      '{KIND_ALLOC, 12'd17,   10'd0,    1'b1, ST_DONE,     10'd96},
      '{KIND_FREE,  12'd0,    10'd32,   1'b0, ST_DONE,     10'd0},
      // double free, misaligned, not a block start
      '{KIND_FREE,  12'd0,    10'd32,   1'b1, ST_BAD_FREE, 10'd0},
      '{KIND_FREE,  12'd0,    10'd24,   1'b1, ST_BAD_FREE, 10'd0},
      '{KIND_FREE,  12'd0,    10'd1008, 1'b1, ST_BAD_FREE, 10'd0},
      // refill the hole, then coalesce everything
      '{KIND_ALLOC, 12'd16,   10'd0,    1'b0, ST_DONE,     10'd0},
      '{KIND_FREE,  12'd0,    10'd64,   1'b0, ST_DONE,     10'd0},
      '{KIND_FREE,  12'd0,    10'd16,   1'b0, ST_DONE,     10'd0},
      '{KIND_FREE,  12'd0,    10'd32,   1'b0, ST_DONE,     10'd0},
      '{KIND_FREE,  12'd0,    10'd96,   1'b0, ST_DONE,     10'd0},
      // near-fit without split, split leaving a small tail block
      '{KIND_ALLOC, 12'd992,  10'd0,    1'b0, ST_DONE,     10'd0},
      '{KIND_FREE,  12'd0,    10'd16,   1'b0, ST_DONE,     10'd0},
      '{KIND_ALLOC, 12'd960,  10'd0,    1'b0, ST_DONE,     10'd0},
      '{KIND_ALLOC, 12'd32,   10'd0,    1'b0, ST_DONE,     10'd0},
      '{KIND_FREE,  12'd0,    10'd992,  1'b0, ST_DONE,     10'd0},
      '{KIND_FREE,  12'd0,    10'd16,   1'b0, ST_DONE,     10'd0}
    };

    shadow_starts = '0;
    shadow_starts[0] = 1'b1;
    shadow_used = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < NUM_DIR; n++) begin
      w.kind = dir_rows[n].kind;
      w.request_bytes = dir_rows[n].req;
      w.release_offset = dir_rows[n].rel;
      want.status = dir_rows[n].st;
      want.data_offset = dir_rows[n].offs;
      send_word(w, dir_rows[n].typed, want);
    end

    // mostly allocs and frees of live blocks, some bad frees
    want = '0;
    for (n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      w.request_bytes = REQ_W'($urandom);
      w.release_offset = OFFS_W'($urandom);
      if (pick < 45 || (pick < 90 && live_offsets.size() == 0)) begin
        w.kind = KIND_ALLOC;
        sz_sel = $urandom_range(0, 9);
        if (sz_sel < 7) begin
          w.request_bytes = REQ_W'($urandom_range(0, 96));
        end else if (sz_sel < 9) begin
          w.request_bytes = REQ_W'($urandom_range(0, 1023));
        end
      end else if (pick < 90) begin
        w.kind = KIND_FREE;
        w.release_offset = OFFS_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
      end else begin
        w.kind = KIND_FREE;
        if ($urandom_range(0, 1) == 0) w.release_offset = OFFS_W'($urandom_range(0, 63) * GRAN);
      end
      send_word(w, 1'b0, want);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
